// ----- rtl/core/ogpu_pkg.sv -----
// Shared types, codes and helpers for the occupancy grid point update core.
`default_nettype none

package ogpu_pkg;

    // Fixed field widths of the ports
    localparam int CELL_IDX_W = 18;
    localparam int ODDS_W     = 7;
    localparam int CLR_CNT_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 32;
    // Row sum: three 32-bit products plus the shifted offset
    localparam int ACC_W      = 34;
    // Widest coordinate any grid axis may use
    localparam int COORD_W    = 8;
    localparam int CELL_W     = ODDS_W + 1;

    // Request codes
    localparam logic [1:0] REQ_POINT = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ODDS_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ODDS_MAX = 3'd5;

    // Cell word: bit 7 hit flag, bits 6:0 odds
    localparam logic [CELL_W-1:0] CELL_RESET = 8'h3F;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Integer part of a Q18.16 sum, truncated toward zero, low COORD_W bits
    function automatic logic [COORD_W-1:0] trunc_coord(input t_acc s);
        logic rnd;
        rnd = s[ACC_W-1] && (s[15:0] != 16'h0000);
        return s[16 +: COORD_W] + COORD_W'(rnd);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ogpu_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module ogpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/ogpu_xform.sv -----
// Point to cell transform: 3x4 fixed-point matrix, truncation and wrap.
`default_nettype none

module ogpu_xform #(
    parameter int X_BITS = 6,
    parameter int Y_BITS = 6,
    parameter int Z_BITS = 6
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic signed [ogpu_pkg::COEF_W-1:0]     i_px,
    input  wire logic signed [ogpu_pkg::COEF_W-1:0]     i_py,
    input  wire logic signed [ogpu_pkg::COEF_W-1:0]     i_pz,
    input  wire logic [ogpu_pkg::CFG_DATA_W-1:0]        i_row_x,
    input  wire logic [ogpu_pkg::CFG_DATA_W-1:0]        i_row_y,
    input  wire logic [ogpu_pkg::CFG_DATA_W-1:0]        i_row_z,
    output logic                                        o_done,
    output logic [X_BITS+Y_BITS+Z_BITS-1:0]             o_cell
);

    import ogpu_pkg::*;

    localparam int ROWS = 3;

    logic                     r_busy;
    logic                     r_done;
    logic [2:0]               r_phase;
    logic signed [COEF_W-1:0] r_p [ROWS];
    logic signed [PROD_W-1:0] r_prod [ROWS];
    t_acc                     r_acc [ROWS];
    logic [X_BITS+Y_BITS+Z_BITS-1:0] r_cell;

    logic [CFG_DATA_W-1:0]    w_row [ROWS];
    logic signed [COEF_W-1:0] w_coef [ROWS];
    logic signed [COEF_W-1:0] w_op;
    logic signed [PROD_W-1:0] w_prod [ROWS];
    t_acc                     w_off [ROWS];
    logic [COORD_W-1:0]       w_coord [ROWS];

    assign w_row[0] = i_row_x;
    assign w_row[1] = i_row_y;
    assign w_row[2] = i_row_z;

    // One multiplier per row, stepping through the x, y and z terms
    always_comb begin
        unique case (r_phase[1:0])
            2'd0:    w_op = r_p[0];
            2'd1:    w_op = r_p[1];
            default: w_op = r_p[2];
        endcase
        for (int r = 0; r < ROWS; r++) begin
            unique case (r_phase[1:0])
                2'd0:    w_coef[r] = w_row[r][15:0];
                2'd1:    w_coef[r] = w_row[r][31:16];
                default: w_coef[r] = w_row[r][47:32];
            endcase
            w_prod[r]  = w_coef[r] * w_op;
            w_off[r]   = {{(ACC_W-COEF_W-8){w_row[r][63]}}, w_row[r][63:48], 8'h00};
            w_coord[r] = trunc_coord(r_acc[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
            end else if (r_busy) begin
                r_phase <= r_phase + 3'd1;
                if (r_phase == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Phases 0..2 multiply, 1..3 accumulate, 4 wraps into the cell index
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p[0] <= i_px;
            r_p[1] <= i_py;
            r_p[2] <= i_pz;
            for (int r = 0; r < ROWS; r++) begin
                r_acc[r] <= w_off[r];
            end
        end else if (r_busy) begin
            for (int r = 0; r < ROWS; r++) begin
                if (r_phase <= 3'd2) begin
                    r_prod[r] <= w_prod[r];
                end
                if (r_phase >= 3'd1 && r_phase <= 3'd3) begin
                    r_acc[r] <= r_acc[r] + ACC_W'(r_prod[r]);
                end
            end
            if (r_phase == 3'd4) begin
                r_cell <= {w_coord[0][X_BITS-1:0], w_coord[1][Y_BITS-1:0],
                           w_coord[2][Z_BITS-1:0]};
            end
        end
    end

    assign o_done = r_done;
    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ----- rtl/core/occupancy_grid_point_update_core.sv -----
// Top level of the occupancy grid point update core.
// Point: the transform, the cell read issue, one read-modify-write, then the output load;
//   one item in flight. Read: the cell read at transfer, then the output load. End of cloud:
//   one queued cell per cycle through the queue and cell memory ports. Next transfer after
//   the result. Reset (synchronous, active low) resets control and the configuration
//   registers, then a pass writes every cell before the first item is taken.
`default_nettype none

module occupancy_grid_point_update_core #(
    parameter int X_BITS      = 6,
    parameter int Y_BITS      = 6,
    parameter int Z_BITS      = 6,
    parameter int QUEUE_DEPTH = 4096
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ogpu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ogpu_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [1:0]                            i_req_type,
    input  wire logic signed [15:0]                    i_point_x,
    input  wire logic signed [15:0]                    i_point_y,
    input  wire logic signed [15:0]                    i_point_z,
    input  wire logic [ogpu_pkg::CELL_IDX_W-1:0]       i_read_index,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [ogpu_pkg::CELL_IDX_W-1:0]            o_cell_index,
    output logic [ogpu_pkg::ODDS_W-1:0]                o_odds_value,
    output logic [1:0]                                 o_status,
    output logic [ogpu_pkg::CLR_CNT_W-1:0]             o_cleared_count
);

    import ogpu_pkg::*;

    localparam int CELL_BITS = X_BITS + Y_BITS + Z_BITS;
    localparam int CELL_COUNT = 1 << CELL_BITS;
    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_EXT_W = (CELL_BITS > CELL_IDX_W) ? CELL_BITS : CELL_IDX_W;
    localparam int CNT_EXT_W = (CNT_W > CLR_CNT_W) ? CNT_W : CLR_CNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_XFORM,
        S_LOOK,
        S_WALK,
        S_RESULT
    } t_state;

    t_state                 r_state;
    logic [CELL_BITS-1:0]   r_clr_addr;
    logic [1:0]             r_req;
    logic [CELL_BITS-1:0]   r_cell;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_walk_idx;
    logic                   r_wq_vld;
    logic                   r_wc_vld;
    logic [CELL_BITS-1:0]   r_wc_cell;

    logic [CFG_DATA_W-1:0]  r_row_x;
    logic [CFG_DATA_W-1:0]  r_row_y;
    logic [CFG_DATA_W-1:0]  r_row_z;
    logic [ODDS_W-1:0]      r_hit_step;
    logic [ODDS_W-1:0]      r_odds_min;
    logic [ODDS_W-1:0]      r_odds_max;

    logic [CELL_BITS-1:0]   r_res_cell;
    logic [ODDS_W-1:0]      r_res_odds;
    logic [1:0]             r_res_status;
    logic [CLR_CNT_W-1:0]   r_res_cleared;

    logic                   r_out_valid;
    logic [CELL_IDX_W-1:0]  r_out_cell;
    logic [ODDS_W-1:0]      r_out_odds;
    logic [1:0]             r_out_status;
    logic [CLR_CNT_W-1:0]   r_out_cleared;

    logic                   w_accept;
    logic                   w_xf_start;
    logic                   w_xf_done;
    logic [CELL_BITS-1:0]   w_xf_cell;
    logic [IDX_EXT_W-1:0]   w_rd_ext;
    logic [IDX_EXT_W-1:0]   w_res_ext;
    logic [CNT_EXT_W-1:0]   w_cnt_ext;

    logic                   w_c_we;
    logic [CELL_BITS-1:0]   w_c_waddr;
    logic [CELL_W-1:0]      w_c_wdata;
    logic [CELL_BITS-1:0]   w_c_raddr;
    logic [CELL_W-1:0]      w_c_rdata;

    logic                   w_q_we;
    logic [QA_W-1:0]        w_q_raddr;
    logic [CELL_BITS-1:0]   w_q_rdata;

    logic                   w_flag;
    logic [ODDS_W-1:0]      w_odds_old;
    logic [ODDS_W+1:0]      w_sum;
    logic [ODDS_W+1:0]      w_lim;
    logic [ODDS_W-1:0]      w_odds_new;
    logic                   w_full;
    logic                   w_do_update;
    logic                   w_walk_issue;
    logic                   w_walk_end;
    logic                   w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_xf_start = w_accept && (i_req_type == REQ_POINT);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_rd_ext  = IDX_EXT_W'(i_read_index);
    assign w_res_ext = IDX_EXT_W'(r_res_cell);
    assign w_cnt_ext = CNT_EXT_W'(r_count);

    ogpu_xform #(
        .X_BITS (X_BITS),
        .Y_BITS (Y_BITS),
        .Z_BITS (Z_BITS)
    ) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_xf_start),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_pz    (i_point_z),
        .i_row_x (r_row_x),
        .i_row_y (r_row_y),
        .i_row_z (r_row_z),
        .o_done  (w_xf_done),
        .o_cell  (w_xf_cell)
    );

    ogpu_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rdata)
    );

    ogpu_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (r_count[QA_W-1:0]),
        .i_wdata (r_cell),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    // Hit update of the looked-up cell: add, limit to max, then raise to min
    always_comb begin
        w_flag     = w_c_rdata[CELL_W-1];
        w_odds_old = w_c_rdata[ODDS_W-1:0];
        w_sum      = {2'b00, w_odds_old} + {{2{r_hit_step[ODDS_W-1]}}, r_hit_step};
        w_lim      = ($signed(w_sum) > $signed({2'b00, r_odds_max}))
                   ? {2'b00, r_odds_max} : w_sum;
        w_odds_new = ($signed(w_lim) < $signed({2'b00, r_odds_min}))
                   ? r_odds_min : w_lim[ODDS_W-1:0];
        w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
        w_do_update = (r_state == S_LOOK) && (r_req == REQ_POINT) && !w_flag && !w_full;
    end

    // End-of-cloud walk: queue read, cell read, cell write with flag cleared
    assign w_walk_issue = (r_walk_idx != r_count);
    assign w_walk_end   = !w_walk_issue && !r_wq_vld && !r_wc_vld;
    assign w_q_raddr    = r_walk_idx[QA_W-1:0];
    assign w_q_we       = w_do_update;

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_c_raddr = w_rd_ext[CELL_BITS-1:0];
            S_XFORM: w_c_raddr = w_xf_cell;
            S_WALK:  w_c_raddr = w_q_rdata;
            default: w_c_raddr = r_cell;
        endcase
        w_c_we    = 1'b0;
        w_c_waddr = r_cell;
        w_c_wdata = {1'b1, w_odds_new};
        unique case (r_state)
            S_CLEAR: begin
                w_c_we    = 1'b1;
                w_c_waddr = r_clr_addr;
                w_c_wdata = CELL_RESET;
            end
            S_LOOK: begin
                w_c_we = w_do_update;
            end
            S_WALK: begin
                w_c_we    = r_wc_vld;
                w_c_waddr = r_wc_cell;
                w_c_wdata = {1'b0, w_c_rdata[ODDS_W-1:0]};
            end
            default: begin
                w_c_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_walk_idx  <= '0;
            r_wq_vld    <= 1'b0;
            r_wc_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_x     <= '0;
            r_row_y     <= '0;
            r_row_z     <= '0;
            r_hit_step  <= 7'd8;
            r_odds_min  <= 7'd0;
            r_odds_max  <= 7'd127;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROW_X:    r_row_x    <= i_cfg_data;
                    CFG_ROW_Y:    r_row_y    <= i_cfg_data;
                    CFG_ROW_Z:    r_row_z    <= i_cfg_data;
                    CFG_HIT_STEP: r_hit_step <= i_cfg_data[ODDS_W-1:0];
                    CFG_ODDS_MIN: r_odds_min <= i_cfg_data[ODDS_W-1:0];
                    CFG_ODDS_MAX: r_odds_max <= i_cfg_data[ODDS_W-1:0];
                    default: ;
                endcase
            end

            // In S_RESULT the output register is reloaded below instead
            if (r_out_valid && i_out_ready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + CELL_BITS'(1);
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_req      <= i_req_type;
                        r_cell     <= w_rd_ext[CELL_BITS-1:0];
                        r_walk_idx <= '0;
                        r_wq_vld   <= 1'b0;
                        r_wc_vld   <= 1'b0;
                        unique case (i_req_type)
                            REQ_POINT: r_state <= S_XFORM;
                            REQ_CLEAR: r_state <= S_WALK;
                            REQ_READ:  r_state <= S_LOOK;
                            REQ_NONE:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_XFORM: begin
                    if (w_xf_done) begin
                        r_cell  <= w_xf_cell;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_res_cell    <= r_cell;
                    r_res_cleared <= '0;
                    r_res_odds    <= w_do_update ? w_odds_new : w_odds_old;
                    if (r_req == REQ_POINT) begin
                        if (w_flag) begin
                            r_res_status <= ST_SKIPPED;
                        end else if (w_full) begin
                            r_res_status <= ST_DROPPED;
                        end else begin
                            r_res_status <= ST_UPDATED;
                            r_count      <= r_count + CNT_W'(1);
                        end
                    end else begin
                        r_res_status <= w_flag ? ST_SKIPPED : ST_UPDATED;
                    end
                    r_state <= S_RESULT;
                end
                S_WALK: begin
                    r_walk_idx <= r_walk_idx + CNT_W'(w_walk_issue);
                    r_wq_vld   <= w_walk_issue;
                    r_wc_vld   <= r_wq_vld;
                    r_wc_cell  <= w_q_rdata;
                    if (w_walk_end) begin
                        r_res_cell    <= '0;
                        r_res_odds    <= '0;
                        r_res_status  <= ST_DONE;
                        r_res_cleared <= w_cnt_ext[CLR_CNT_W-1:0];
                        r_count       <= '0;
                        r_state       <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_cell    <= w_res_ext[CELL_IDX_W-1:0];
                        r_out_odds    <= r_res_odds;
                        r_out_status  <= r_res_status;
                        r_out_cleared <= r_res_cleared;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_index    = r_out_cell;
    assign o_odds_value    = r_out_odds;
    assign o_status        = r_out_status;
    assign o_cleared_count = r_out_cleared;

endmodule

`default_nettype wire

// ----- rtl/core/ogpu_checker.sv -----
// Port-level checks for the occupancy grid point update core, with bind.
`default_nettype none

module ogpu_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_in_valid,
    input wire logic                                  o_in_ready,
    input wire logic [1:0]                            i_req_type,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_ready,
    input wire logic [ogpu_pkg::CELL_IDX_W-1:0]       o_cell_index,
    input wire logic [ogpu_pkg::ODDS_W-1:0]           o_odds_value,
    input wire logic [1:0]                            o_status,
    input wire logic [ogpu_pkg::CLR_CNT_W-1:0]        o_cleared_count
);

    import ogpu_pkg::*;

    // No result may appear straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cell_index)
            && $stable(o_odds_value) && $stable(o_status) && $stable(o_cleared_count))
        else $error("stalled result changed");

    // One item at a time: a real request closes the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_req_type != REQ_NONE |=> !o_in_ready)
        else $error("input open right after a request transfer");

    // End-of-cloud result carries zero cell and odds
    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_DONE |-> o_cell_index == '0 && o_odds_value == '0)
        else $error("end-of-cloud result with nonzero cell or odds");

    // Only end-of-cloud results report cleared flags
    a_cleared_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_cleared_count == '0)
        else $error("cleared count on a cell result");

endmodule

bind occupancy_grid_point_update_core ogpu_checker u_ogpu_checker (.*);

`default_nettype wire
